// ===== rtl/uts_pkg.sv =====
// Shared types, constants and byte classifiers for the UTF-8 text sanitizer.
package uts_pkg;

  localparam logic [7:0] QMARK       = 8'h3F;
  localparam logic [7:0] SPACE       = 8'h20;
  localparam logic [7:0] CARET       = 8'h5E;
  localparam logic [7:0] DEL_CHAR    = 8'h7F;
  localparam logic [7:0] DIGIT_0     = 8'h30;
  localparam logic [7:0] DIGIT_9     = 8'h39;
  localparam logic [7:0] LIMIT_RESET = 8'd96;

  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // One queued command: up to four output words built from a single input word.
  typedef struct packed {
    logic [3:0][7:0] bytes;  // word i goes out as bytes[i]
    logic [2:0]      cnt;    // number of words, 1..4
    logic            mark;   // bare end marker (out_valid 0)
    logic            last;   // final word carries last
  } cmd_t;

  // Expected sequence length for a lead byte; 0 for an illegal lead.
  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= 8'hC2 && b <= 8'hDF)      len = 3'd2;
    else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
    else if (b >= 8'hF0 && b <= 8'hF4) len = 3'd4;
    return len;
  endfunction

  // Continuation check; second byte is narrowed after E0, ED, F0 and F4.
  function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                   input logic [7:0] b);
    logic ok;
    ok = (b >= 8'h80) && (b <= 8'hBF);
    if (pos == 2'd1) begin
      if (lead == 8'hE0 && b < 8'hA0)  ok = 1'b0;
      if (lead == 8'hED && b >= 8'hA0) ok = 1'b0;
      if (lead == 8'hF0 && b < 8'h90)  ok = 1'b0;
      if (lead == 8'hF4 && b >= 8'h90) ok = 1'b0;
    end
    return ok;
  endfunction

endpackage

// ===== rtl/utf8_text_sanitizer_core.sv =====
// UTF-8 text sanitizer: top level joining front end, command queue and back end.
//
// Input channel (in_valid_i/in_ready_o): one word per string byte, data_byte_i,
// with end_of_text_i set on the terminator word (its data byte is ignored).
// Output channel (res_valid_o/res_ready_i): sanitized bytes on out_byte_o with
// out_valid_o high; last_o marks the final word of a string. A terminator that
// flushes nothing yields one bare marker word (out_valid_o low, byte 0).
// Config channel (cfg_valid_i/cfg_ready_o): writes output_limit; always ready.
// Write it only while no string is in flight.
// First output word: registered in a queue entry, then in the back end command register.
// Throughput: one input word per cycle while the receiver is ready and each word yields
// at most one output word; a word yielding n words (full multibyte sequence, or '?'
// flush plus a fresh byte) holds the back end until all n words are accepted. The
// two-entry command queue lets the front end keep taking words during such bursts.
// Receiver stall: the back end holds its word, the queue fills, and in_ready_o
// drops once both queue entries are taken.
// Reset (rst_ni low, asynchronous): string state cleared, queue empty, limit 96.
module utf8_text_sanitizer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_text_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic       last_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic          push_valid, push_ready;
  uts_pkg::cmd_t push_cmd;
  logic          q_valid, q_pop;
  uts_pkg::cmd_t q_cmd;

  // Limit register has no back pressure.
  assign cfg_ready_o = 1'b1;

  uts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push_ready_i  (push_ready),
    .push_valid_o  (push_valid),
    .push_cmd_o    (push_cmd)
  );

  uts_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  uts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .cmd_i       (q_cmd),
    .res_valid_o (res_valid_o),
    .res_ready_i (res_ready_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/uts_front.sv =====
// Front end: holds the string state, classifies each input word into a command.
module uts_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_text_i,
  input  logic          cfg_valid_i,
  input  logic [7:0]    cfg_data_i,
  input  logic          push_ready_i,
  output logic          push_valid_o,
  output uts_pkg::cmd_t push_cmd_o
);

  logic [7:0] limit_q;
  logic [7:0] held_q [3];
  logic [7:0] held_d [3];
  logic [1:0] hc_q, hc_d;
  logic [2:0] sl_q, sl_d;
  logic       caret_q, caret_d;
  logic [7:0] ec_q, ec_d;
  logic       st_q, st_d;

  logic       in_fire;
  logic [1:0] flush_k;
  logic       do_fresh, do_complete;
  logic [7:0] avail0;
  logic [1:0] nq;
  logic       st1;
  logic [7:0] ec1;
  logic       f_emit;
  logic [7:0] f_byte;
  logic [2:0] f_len;
  logic       fits;
  logic [8:0] ec_plus;
  uts_pkg::cmd_t cmd;

  assign in_ready_o   = push_ready_i;
  assign in_fire      = in_valid_i && in_ready_o;
  assign push_valid_o = in_fire && (cmd.cnt != 3'd0);
  assign push_cmd_o   = cmd;

  always_comb begin
    hc_d    = hc_q;
    sl_d    = sl_q;
    caret_d = caret_q;
    ec_d    = ec_q;
    st_d    = st_q;
    for (int i = 0; i < 3; i++) held_d[i] = held_q[i];
    cmd         = '0;
    flush_k     = 2'd0;
    do_fresh    = 1'b0;
    do_complete = 1'b0;
    f_emit      = 1'b0;
    f_byte      = 8'h00;
    f_len       = uts_pkg::lead_len(data_byte_i);
    fits        = 1'b0;
    ec_plus     = 9'd0;

    // Dispatch
    if (end_of_text_i) begin
      flush_k = hc_q;
    end else if (hc_q == 2'd0) begin
      do_fresh = 1'b1;
    end else if (!uts_pkg::cont_ok(held_q[0], hc_q, data_byte_i)) begin
      flush_k  = hc_q;
      do_fresh = 1'b1;
    end else if ({1'b0, hc_q} + 3'd1 >= sl_q) begin
      do_complete = 1'b1;
    end

    // Flush of held bytes as '?', limited by room
    avail0 = (st_q || ec_q >= limit_q) ? 8'd0 : 8'(limit_q - ec_q);
    if ({6'd0, flush_k} > avail0) begin
      nq  = avail0[1:0];
      st1 = 1'b1;
    end else begin
      nq  = flush_k;
      st1 = st_q;
    end
    ec1 = 8'(ec_q + {6'd0, nq});
    if (flush_k != 2'd0) begin
      hc_d = 2'd0;
      sl_d = 3'd0;
    end
    ec_d = ec1;
    st_d = st1;

    // Fresh byte handling
    if (do_fresh) begin
      caret_d = 1'b0;
      if (!(caret_q && data_byte_i >= uts_pkg::DIGIT_0 && data_byte_i <= uts_pkg::DIGIT_9))
      begin
        if (st1 || ec1 >= limit_q) begin
          st_d = 1'b1;
        end else if (data_byte_i[7]) begin
          if (f_len == 3'd0) begin
            f_emit = 1'b1;
            f_byte = uts_pkg::QMARK;
          end else begin
            held_d[0] = data_byte_i;
            hc_d      = 2'd1;
            sl_d      = f_len;
          end
        end else if (data_byte_i == uts_pkg::CARET) begin
          caret_d = 1'b1;
        end else begin
          f_emit = 1'b1;
          f_byte = (data_byte_i < 8'd32 || data_byte_i == uts_pkg::DEL_CHAR)
                   ? uts_pkg::SPACE : data_byte_i;
        end
      end
      ec_d = 8'(ec1 + {7'd0, f_emit});
    end

    // Command for flush and/or fresh byte
    for (int i = 0; i < 4; i++) begin
      cmd.bytes[i] = (3'(i) < {1'b0, nq}) ? uts_pkg::QMARK : f_byte;
    end
    cmd.cnt = {1'b0, nq} + {2'd0, f_emit};

    if (do_complete) begin
      ec_plus = {1'b0, ec_q} + {6'd0, sl_q};
      fits    = !st_q && (ec_plus <= {1'b0, limit_q});
      hc_d    = 2'd0;
      sl_d    = 3'd0;
      if (fits) begin
        for (int i = 0; i < 3; i++) cmd.bytes[i] = held_q[i];
        cmd.bytes[3]                  = data_byte_i;
        cmd.bytes[2'(sl_q - 3'd1)]    = data_byte_i;
        cmd.cnt                       = sl_q;
        ec_d                          = ec_plus[7:0];
      end else begin
        st_d = 1'b1;
      end
    end else if (!end_of_text_i && !do_fresh && flush_k == 2'd0) begin
      // Continuation kept for later
      held_d[hc_q] = data_byte_i;
      hc_d         = 2'(hc_q + 2'd1);
    end

    if (end_of_text_i) begin
      if (nq == 2'd0) begin
        cmd.bytes = '0;
        cmd.cnt   = 3'd1;
        cmd.mark  = 1'b1;
      end
      cmd.last = 1'b1;
      hc_d     = 2'd0;
      sl_d     = 3'd0;
      caret_d  = 1'b0;
      ec_d     = 8'd0;
      st_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= uts_pkg::LIMIT_RESET;
      hc_q    <= 2'd0;
      sl_q    <= 3'd0;
      caret_q <= 1'b0;
      ec_q    <= 8'd0;
      st_q    <= 1'b0;
      for (int i = 0; i < 3; i++) held_q[i] <= 8'h00;
    end else begin
      if (cfg_valid_i) limit_q <= cfg_data_i;
      if (in_fire) begin
        hc_q    <= hc_d;
        sl_q    <= sl_d;
        caret_q <= caret_d;
        ec_q    <= ec_d;
        st_q    <= st_d;
        for (int i = 0; i < 3; i++) held_q[i] <= held_d[i];
      end
    end
  end

endmodule

// ===== rtl/uts_queue.sv =====
// Short command queue between front and back ends.
module uts_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  uts_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_i,
  output uts_pkg::cmd_t pop_cmd_o
);

  uts_pkg::cmd_t                mem_q [uts_pkg::QueueDepth];
  logic [uts_pkg::QPtrW-1:0]    wr_q, rd_q;
  logic [uts_pkg::QCntW-1:0]    cnt_q;
  logic                         do_push, do_pop;

  assign push_ready_o = cnt_q != uts_pkg::QCntW'(uts_pkg::QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_cmd_o    = mem_q[rd_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == uts_pkg::QPtrW'(uts_pkg::QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == uts_pkg::QPtrW'(uts_pkg::QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/uts_back.sv =====
// Back end: plays a command out one word per accepted output handshake.
module uts_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_pop_o,
  input  uts_pkg::cmd_t cmd_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_valid_o,
  output logic          last_o
);

  uts_pkg::cmd_t cmd_q;
  logic          busy_q;
  logic [1:0]    idx_q;
  logic          final_word;
  logic          res_fire;

  assign final_word  = ({1'b0, idx_q} == cmd_q.cnt - 3'd1);
  assign res_fire    = busy_q && res_ready_i;
  assign cmd_pop_o   = cmd_valid_i && (!busy_q || (res_fire && final_word));
  assign res_valid_o = busy_q;
  assign out_byte_o  = cmd_q.bytes[idx_q];
  assign out_valid_o = !cmd_q.mark;
  assign last_o      = cmd_q.last && final_word;

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 2'd0;
    end else if (cmd_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= 2'd0;
    end else if (res_fire) begin
      if (final_word) busy_q <= 1'b0;
      idx_q <= idx_q + 2'd1;
    end
  end

endmodule

// ===== rtl/uts_checker.sv =====
// Port-level checks for the sanitizer top level, bound to it.
module uts_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       res_valid_o,
  input logic       res_ready_i,
  input logic [7:0] out_byte_o,
  input logic       out_valid_o,
  input logic       last_o,
  input logic       cfg_ready_o
);

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(out_byte_o) && $stable(last_o))
    else $error("output word changed while stalled");

  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !out_valid_o |-> last_o && (out_byte_o == 8'h00))
    else $error("bare end marker without last or with nonzero byte");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

  a_no_out_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_o)
    else $error("output word present right after reset");

endmodule

bind utf8_text_sanitizer_core uts_checker u_chk (.*);
